// ===== rtl/dcs_pkg.sv =====
// Types and constants shared by the descriptor command splitter.
// Character codes, input op and result kind codes, register indexes, flag and result records.
// Depends on nothing.
package dcs_pkg;

    localparam int LINE_OUT_BITS = 24;
    localparam int CHAR_BITS     = 16;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = 2;
    localparam int Q_CNT_BITS    = 3;

    localparam logic [CHAR_BITS-1:0] CH_HASH   = 16'h0023;
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = 16'h003B;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 16'h000D;
    localparam logic [CHAR_BITS-1:0] CH_LF     = 16'h000A;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 16'h0009;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_BITS-1:0] CH_BSLASH = 16'h005C;

    localparam logic CFG_SEMICOLON_MODE = 1'b0;
    localparam logic CFG_INDENT_MODE    = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_END     = 2'd1,
        OP_INVALID = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic at_line_start;
        logic indented;
        logic skip_comment;
        logic in_single_quotes;
        logic in_double_quotes;
        logic escape_pending;
        logic command_nonempty;
    } t_flags;

    localparam t_flags FLAGS_CLEAR = '{
        at_line_start:    1'b1,
        indented:         1'b0,
        skip_comment:     1'b0,
        in_single_quotes: 1'b0,
        in_double_quotes: 1'b0,
        escape_pending:   1'b0,
        command_nonempty: 1'b0
    };

    typedef struct packed {
        logic [1:0]               kind;
        logic [CHAR_BITS-1:0]     char_code;
        logic [LINE_OUT_BITS-1:0] line_number;
        logic                     last;
    } t_result;

endpackage

// ===== rtl/descriptor_command_splitter.sv =====
// Descriptor command splitter: decoded character stream in, command characters and markers out.
// Top level: input register, step logic, four-entry result queue, configuration registers.
// Depends on dcs_pkg and dcs_step.
//
// Usage:
//   Input items arrive on s_axis: tdata[1:0] op (character, end of input, invalid character),
//   tdata[17:2] character code. Each item yields zero, one or two results on m_axis:
//   tuser is the kind (command character, end of command, invalid character error),
//   tdata[15:0] the character, tdata[39:16] the line the command began on, tlast marks the
//   final result of an input item. Items that yield nothing (carriage returns, blanks at a
//   line start, comment text) leave no trace on m_axis.
//   A result passes through the input register, then the result queue, before it is
//   offered on m_axis. Throughput: one item per cycle while each item yields at most one
//   result and m_axis is ready; the output moves one result per cycle while m_axis_tready
//   is high, so items yielding two results (escaped characters, indent breaks) fill the
//   queue faster than it drains.
//   When m_axis stalls, results collect in the four-entry queue; s_axis_tready drops once the
//   queue cannot take two more results and an item waits in the input register.
//   Reset (synchronous, i_rst_n low) empties the queue, drops the input register, restores
//   the parser flags and line counters and sets semicolon mode on, indent mode off.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 semicolon mode,
//   1 indent mode); write only while the block is idle.
module descriptor_command_splitter
    import dcs_pkg::*;
#(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[1:0], char_code[17:2], zero[23:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // char_code_res[15:0], line_number[39:16]
    output logic        m_axis_tlast,   // last
    output logic [1:0]  m_axis_tuser    // kind[1:0]
);

    logic                  r_semicolon_mode;
    logic                  r_indent_mode;

    logic                  r_in_valid;
    logic [1:0]            r_in_op;
    logic [CHAR_BITS-1:0]  r_in_char;

    t_flags                r_flags;
    logic [LINE_BITS-1:0]  r_newline_count;
    logic [LINE_BITS-1:0]  r_command_line;

    t_flags                n_flags;
    logic [LINE_BITS-1:0]  n_newline_count;
    logic [LINE_BITS-1:0]  n_command_line;
    logic [1:0]            step_count;
    t_result               step_res0;
    t_result               step_res1;

    t_result               r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic [Q_CNT_BITS-1:0] n_count;

    logic                  process;
    logic                  pop;
    logic                  in_accept;
    logic [Q_CNT_BITS-1:0] push_count;
    t_result               head;

    dcs_step #(
        .LINE_BITS(LINE_BITS)
    ) u_step (
        .i_semicolon_mode(r_semicolon_mode),
        .i_indent_mode   (r_indent_mode),
        .i_op            (r_in_op),
        .i_char          (r_in_char),
        .i_flags         (r_flags),
        .i_newline_count (r_newline_count),
        .i_command_line  (r_command_line),
        .o_flags         (n_flags),
        .o_newline_count (n_newline_count),
        .o_command_line  (n_command_line),
        .o_count         (step_count),
        .o_res0          (step_res0),
        .o_res1          (step_res1)
    );

    assign process       = r_in_valid && (r_count <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || process;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_count    = process ? Q_CNT_BITS'(step_count) : '0;
    assign n_count       = r_count + push_count - Q_CNT_BITS'(pop);

    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {head.line_number, head.char_code};
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = head.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semicolon_mode <= 1'b1;
            r_indent_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEMICOLON_MODE: r_semicolon_mode <= i_cfg_data[0];
                CFG_INDENT_MODE:    r_indent_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= s_axis_tdata[1:0];
            r_in_char <= s_axis_tdata[17:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags         <= FLAGS_CLEAR;
            r_newline_count <= '0;
            r_command_line  <= '0;
        end else if (process) begin
            r_flags         <= n_flags;
            r_newline_count <= n_newline_count;
            r_command_line  <= n_command_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            if (step_count != 2'd0) begin
                r_q[r_wr_ptr] <= step_res0;
            end
            if (step_count == 2'd2) begin
                r_q[r_wr_ptr + Q_PTR_BITS'(1)] <= step_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(push_count);
            r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(pop);
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/dcs_step.sv =====
// Per-item update of the splitter: parser flags, line counters and up to two results.
// Pure combinational logic between the input register and the result queue.
// Depends on dcs_pkg.
module dcs_step
    import dcs_pkg::*;
#(
    parameter int LINE_BITS = 24
) (
    input  logic                 i_semicolon_mode,
    input  logic                 i_indent_mode,
    input  logic [1:0]           i_op,
    input  logic [CHAR_BITS-1:0] i_char,
    input  t_flags               i_flags,
    input  logic [LINE_BITS-1:0] i_newline_count,
    input  logic [LINE_BITS-1:0] i_command_line,
    output t_flags               o_flags,
    output logic [LINE_BITS-1:0] o_newline_count,
    output logic [LINE_BITS-1:0] o_command_line,
    output logic [1:0]           o_count,
    output t_result              o_res0,
    output t_result              o_res1
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    t_flags               f;
    logic [LINE_BITS-1:0] nl;
    logic [LINE_BITS-1:0] cl;
    logic [1:0]           cnt;
    t_result              res0;
    t_result              res1;
    logic                 go;
    logic                 blank;
    logic                 is_lf;

    function automatic t_result mk_result(t_kind kind, logic [CHAR_BITS-1:0] ch,
                                          logic [LINE_BITS-1:0] line);
        logic [31:0] wide;
        t_result     r;
        wide          = 32'(line);
        r.kind        = kind;
        r.char_code   = ch;
        r.line_number = wide[LINE_OUT_BITS-1:0];
        r.last        = 1'b0;
        return r;
    endfunction

    always_comb begin
        f     = i_flags;
        nl    = i_newline_count;
        cl    = i_command_line;
        cnt   = 2'd0;
        res0  = '0;
        res1  = '0;
        go    = 1'b1;
        blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
        is_lf = (i_char == CH_LF);

        unique case (i_op)
            OP_CHAR: begin
                if (i_char == CH_CR) begin
                    go = 1'b0;
                end
                if (go) begin
                    if (is_lf && nl != LINE_MAX) begin
                        nl = nl + LINE_BITS'(1);
                    end
                    if (blank && f.at_line_start) begin
                        f.indented = 1'b1;
                    end
                    if (f.at_line_start && (blank || is_lf)) begin
                        go = 1'b0;
                    end
                end
                if (go) begin
                    if (f.at_line_start && i_indent_mode && !f.indented && f.command_nonempty) begin
                        res0 = mk_result(KIND_END, '0, cl);
                        cnt  = 2'd1;
                        f    = FLAGS_CLEAR;
                    end
                    if (f.at_line_start) begin
                        if (i_char == CH_HASH) begin
                            f.skip_comment = 1'b1;
                        end
                        f.at_line_start = 1'b0;
                    end
                    if (is_lf) begin
                        f.indented      = 1'b0;
                        f.at_line_start = 1'b1;
                        if (f.skip_comment) begin
                            f.skip_comment = 1'b0;
                            go             = 1'b0;
                        end
                    end
                end
                if (go && f.skip_comment) begin
                    go = 1'b0;
                end
                if (go && i_char == CH_BSLASH && (f.in_single_quotes || f.in_double_quotes)
                        && !f.escape_pending) begin
                    f.escape_pending = 1'b1;
                    go               = 1'b0;
                end
                if (go) begin
                    if (i_char == CH_SQUOTE && !f.in_double_quotes && !f.escape_pending) begin
                        f.in_single_quotes = !f.in_single_quotes;
                    end
                    if (i_char == CH_DQUOTE && !f.in_single_quotes && !f.escape_pending) begin
                        f.in_double_quotes = !f.in_double_quotes;
                    end
                    if (i_char == CH_SEMI && i_semicolon_mode && !f.in_single_quotes
                            && !f.in_double_quotes) begin
                        if (f.command_nonempty) begin
                            res0 = mk_result(KIND_END, '0, cl);
                            cnt  = 2'd1;
                        end
                        f  = FLAGS_CLEAR;
                        go = 1'b0;
                    end
                end
                if (go) begin
                    if (!f.command_nonempty) begin
                        cl                 = (nl != LINE_MAX) ? nl + LINE_BITS'(1) : LINE_MAX;
                        f.command_nonempty = 1'b1;
                    end
                    if (f.escape_pending) begin
                        res0             = mk_result(KIND_CHAR, CH_BSLASH, cl);
                        f.escape_pending = 1'b0;
                        res1             = mk_result(KIND_CHAR, i_char, cl);
                        cnt              = 2'd2;
                    end else if (cnt == 2'd0) begin
                        res0 = mk_result(KIND_CHAR, i_char, cl);
                        cnt  = 2'd1;
                    end else begin
                        res1 = mk_result(KIND_CHAR, i_char, cl);
                        cnt  = 2'd2;
                    end
                end
            end
            OP_END: begin
                if (f.command_nonempty) begin
                    res0 = mk_result(KIND_END, '0, cl);
                    cnt  = 2'd1;
                end
                f  = FLAGS_CLEAR;
                nl = '0;
                cl = '0;
            end
            OP_INVALID: begin
                res0 = mk_result(KIND_ERROR, '0, cl);
                cnt  = 2'd1;
                f    = FLAGS_CLEAR;
                nl   = '0;
                cl   = '0;
            end
            default: begin
            end
        endcase

        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign o_flags         = f;
    assign o_newline_count = nl;
    assign o_command_line  = cl;
    assign o_count         = cnt;
    assign o_res0          = res0;
    assign o_res1          = res1;

endmodule

// ===== rtl/dcs_checker.sv =====
// Port-level checks for the descriptor command splitter, bound to the top level.
// Watches reset, the output queue and the shape of the result items.
// Depends on dcs_pkg and descriptor_command_splitter.
module dcs_checker
    import dcs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_marker_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_CHAR |-> m_axis_tdata[15:0] == '0)
        else $error("end or error item carries a character");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast)
        else $error("error item not marked last");

    a_stall_only_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind descriptor_command_splitter dcs_checker u_dcs_checker (.*);

// ===== tb/command_stream_checker.sv =====
// Scoreboard for the descriptor command splitter: mirrors the parser and its two mode registers.
// Watches the configuration port and both stream channels, predicts and compares every result.
// Depends on dcs_pkg.
module command_stream_checker
    import dcs_pkg::*;
#(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[1:0], char_code[17:2], zero[23:18]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // char_code_res[15:0], line_number[39:16]
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser,   // kind[1:0]
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    typedef struct packed {
        t_kind                    kind;
        logic [CHAR_BITS-1:0]     code;
        logic [LINE_OUT_BITS-1:0] line;
        logic                     last;
    } split_out_t;

    logic semi_ends = 1'b1;
    logic indent_ends = 1'b0;

    logic line_start;
    logic indented_line;
    logic in_comment;
    logic in_squote;
    logic in_dquote;
    logic held_bslash;
    logic cmd_open;
    logic [LINE_BITS-1:0] nl_count;
    logic [LINE_BITS-1:0] cmd_line;

    split_out_t emit_buf [2];
    int         emit_cnt;
    split_out_t expected_q [$];

    task automatic push_emit(input t_kind kind, input logic [CHAR_BITS-1:0] code);
        emit_buf[emit_cnt] = '{kind: kind, code: code,
                               line: LINE_OUT_BITS'(cmd_line), last: 1'b0};
        emit_cnt++;
    endtask

    task automatic clear_flags();
        line_start = 1'b1;
        indented_line = 1'b0;
        in_comment = 1'b0;
        in_squote = 1'b0;
        in_dquote = 1'b0;
        held_bslash = 1'b0;
        cmd_open = 1'b0;
    endtask

    task automatic close_command();
        if (cmd_open) push_emit(KIND_END, '0);
        clear_flags();
    endtask

    task automatic reset_parser();
        clear_flags();
        nl_count = '0;
        cmd_line = '0;
    endtask

    task automatic parse_char(input logic [CHAR_BITS-1:0] c);
        logic blank;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        if (c == CH_CR) return;
        if (c == CH_LF && nl_count != LINE_MAX) nl_count = nl_count + 1'b1;
        if (blank && line_start) indented_line = 1'b1;
        if (line_start && (blank || c == CH_LF)) return;
        if (line_start) begin
            // indent break: close the pending command, then take c as a fresh line start
            if (indent_ends && !indented_line && cmd_open) close_command();
            if (c == CH_HASH) in_comment = 1'b1;
            line_start = 1'b0;
        end
        if (c == CH_LF) begin
            indented_line = 1'b0;
            line_start = 1'b1;
            if (in_comment) begin
                in_comment = 1'b0;
                return;
            end
        end
        if (in_comment) return;
        if (c == CH_BSLASH && (in_squote || in_dquote) && !held_bslash) begin
            held_bslash = 1'b1;
            return;
        end
        if (c == CH_SQUOTE && !in_dquote && !held_bslash) in_squote = !in_squote;
        if (c == CH_DQUOTE && !in_squote && !held_bslash) in_dquote = !in_dquote;
        if (c == CH_SEMI && semi_ends && !in_squote && !in_dquote) begin
            close_command();
            return;
        end
        if (!cmd_open) begin
            cmd_line = (nl_count != LINE_MAX) ? nl_count + 1'b1 : LINE_MAX;
            cmd_open = 1'b1;
        end
        if (held_bslash) begin
            push_emit(KIND_CHAR, CH_BSLASH);
            held_bslash = 1'b0;
        end
        push_emit(KIND_CHAR, c);
    endtask

    task automatic parse_item(input logic [1:0] op, input logic [CHAR_BITS-1:0] c);
        split_out_t item;
        emit_cnt = 0;
        case (op)
            OP_CHAR: parse_char(c);
            OP_END: begin
                close_command();
                reset_parser();
            end
            OP_INVALID: begin
                push_emit(KIND_ERROR, '0);
                reset_parser();
            end
            default: ;
        endcase
        for (int i = 0; i < emit_cnt; i++) begin
            item = emit_buf[i];
            item.last = (i == emit_cnt - 1);
            expected_q.insert(expected_q.size(), item);
        end
    endtask

    always @(posedge i_clk) begin
        split_out_t got;
        split_out_t want;
        if (!i_rst_n) begin
            semi_ends = 1'b1;
            indent_ends = 1'b0;
            reset_parser();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEMICOLON_MODE: semi_ends = i_cfg_data[0];
                    CFG_INDENT_MODE:    indent_ends = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_item(s_axis_tdata[1:0], s_axis_tdata[17:2]);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{kind: t_kind'(m_axis_tuser), code: m_axis_tdata[15:0],
                        line: m_axis_tdata[39:16], last: m_axis_tlast};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d char=%h line=%0d last=%0b",
                             $realtime, got.kind, got.code, got.line, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected kind/char/line/last %0d/%h/%0d/%0b, got %0d/%h/%0d/%0b",
                                 $realtime, want.kind, want.code, want.line, want.last,
                                 got.kind, got.code, got.line, got.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/tb_descriptor_command_splitter.sv =====
// Top of the descriptor command splitter testbench: clock, reset, stimulus and verdict.
// Drives text-like item streams through several mode settings with random idling on both sides.
// Depends on dcs_pkg, descriptor_command_splitter and command_stream_checker.
module tb_descriptor_command_splitter
    import dcs_pkg::*;
();

    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 16'h0061;
    localparam logic [CHAR_BITS-1:0] CH_TILDE   = 16'h007E;
    localparam int                   IDLE_LIMIT = 1000;
    localparam int                   PHASE_ITEMS = 210;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [0:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // op[1:0], char_code[17:2], zero[23:18]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // char_code_res[15:0], line_number[39:16]
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;         // kind[1:0]

    int fail_count;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_pct = 0;
    logic [7:0] pattern_cnt = '0;

    descriptor_command_splitter #(.LINE_BITS(24)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    command_stream_checker #(.LINE_BITS(24)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: stall density changes each time the 8-bit pattern counter wraps
    always @(posedge i_clk) begin
        pattern_cnt <= pattern_cnt + 1'b1;
        if (pattern_cnt == '0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                2: stall_pct <= 40;
                default: stall_pct <= 75;
            endcase
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[descriptor_command_splitter] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [CHAR_BITS-1:0] ch);
        int gap;
        s_axis_tdata <= {6'b0, ch, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 9);
            gap = (gap < 3) ? 0 : $urandom_range(1, (gap < 8) ? 4 : 20);
            burst_left = $urandom_range(1, 48);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [CHAR_BITS-1:0] body_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      return CH_LOWER_A + CHAR_BITS'($urandom_range(0, 25));
        else if (r < 50) return CH_SPACE;
        else if (r < 54) return CH_TAB;
        else if (r < 62) return CH_SEMI;
        else if (r < 69) return CH_SQUOTE;
        else if (r < 76) return CH_DQUOTE;
        else if (r < 83) return CH_BSLASH;
        else if (r < 86) return CH_HASH;
        else if (r < 88) return CH_CR;
        else if (r < 90) return CH_LF;
        else if (r < 96) return CHAR_BITS'($urandom_range(CH_SPACE, CH_TILDE));
        else             return CHAR_BITS'($urandom);
    endfunction

    task automatic send_line();
        int n_lead;
        int n_body;
        n_lead = ($urandom_range(0, 3) > 1) ? $urandom_range(1, 3) : 0;
        repeat (n_lead) send_item(OP_CHAR, $urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        if ($urandom_range(0, 9) == 0) send_item(OP_CHAR, CH_HASH);
        n_body = $urandom_range(0, 12);
        repeat (n_body) send_item(OP_CHAR, body_char());
        if ($urandom_range(0, 4) == 0) send_item(OP_CHAR, CH_CR);
        send_item(OP_CHAR, CH_LF);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_modes(input logic semi, input logic indent);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SEMICOLON_MODE;
        i_cfg_data <= semi;
        @(posedge i_clk);
        i_cfg_index <= CFG_INDENT_MODE;
        i_cfg_data <= indent;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] modes [6];
        int target;
        int r;
        modes = '{2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b01};   // {semicolon, indent}
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset modes: semicolon ends, indentation ignored
        send_item(OP_CHAR, CH_LOWER_A);
        send_item(OP_CHAR, CH_SEMI);
        send_item(OP_CHAR, CH_SEMI);
        send_item(OP_CHAR, CH_HASH);
        send_item(OP_CHAR, CH_LF);
        send_item(OP_CHAR, CH_DQUOTE);
        send_item(OP_CHAR, CH_BSLASH);
        send_item(OP_CHAR, CH_DQUOTE);
        send_item(OP_CHAR, CH_DQUOTE);
        send_item(OP_CHAR, CH_SEMI);
        send_item(OP_CHAR, CH_CR);
        send_item(OP_CHAR, 16'hFFFF);
        send_item(OP_CHAR, 16'h0000);
        send_item(OP_CHAR, CH_LF);
        send_item(OP_END, '0);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_CHAR, CH_LOWER_A);
        send_item(OP_INVALID, 16'hFFFF);
        settle();

        // indent break on a line that starts at column zero
        set_modes(1'b1, 1'b1);
        send_item(OP_CHAR, CH_LOWER_A);
        send_item(OP_CHAR, CH_LF);
        send_item(OP_CHAR, CH_SPACE);
        send_item(OP_CHAR, CH_LOWER_A);
        send_item(OP_CHAR, CH_LF);
        send_item(OP_CHAR, CH_LOWER_A);
        send_item(OP_END, '0);
        settle();

        foreach (modes[p]) begin
            set_modes(modes[p][1], modes[p][0]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 84)
                    send_line();
                else if (r < 90)
                    repeat ($urandom_range(1, 6)) send_item(OP_CHAR, CHAR_BITS'($urandom));
                else if (r < 95)
                    send_item(OP_END, CHAR_BITS'($urandom));
                else if (r < 98)
                    send_item(OP_INVALID, CHAR_BITS'($urandom));
                else
                    send_item(OP_UNUSED, CHAR_BITS'($urandom));
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[descriptor_command_splitter] OK");
        else
            $display("[descriptor_command_splitter] ERROR");
        $finish;
    end

endmodule
